@@ rtl/core/mac_oui_ssid_ignore_filter_assert.svh @@
// Assertion macros for the ignore filter, switched off by ASSERT_OFF
`ifndef MAC_OUI_SSID_IGNORE_FILTER_ASSERT_SVH
`define MAC_OUI_SSID_IGNORE_FILTER_ASSERT_SVH
`ifndef ASSERT_OFF
`define MOSIF_ASSERT_IMP(lbl, clk, rstn, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (con)) \
    else $error("assertion failed");
`define MOSIF_ASSERT_NXT(lbl, clk, rstn, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (con)) \
    else $error("assertion failed");
`else
`define MOSIF_ASSERT_IMP(lbl, clk, rstn, ant, con)
`define MOSIF_ASSERT_NXT(lbl, clk, rstn, ant, con)
`endif
`endif

@@ rtl/core/mosif_pkg.sv @@
// Shared constants, codes and types of the ignore filter
package mosif_pkg;

  localparam int unsigned ENTRIES   = 16;
  localparam int unsigned VALUE_MAX = 32;
  localparam int unsigned SSID_CAP  = 32;

  localparam int unsigned EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned VW = $clog2(VALUE_MAX);
  localparam int unsigned LW = $clog2(VALUE_MAX + 1);
  localparam int unsigned JW = (LW > 6) ? LW : 6;
  localparam int unsigned RAM_AW    = EW + VW;
  localparam int unsigned RAM_DEPTH = 1 << RAM_AW;

  localparam logic [7:0] TYPE_MAC   = 8'd0;
  localparam logic [7:0] TYPE_OUI   = 8'd1;
  localparam logic [7:0] TYPE_SSID  = 8'd2;
  localparam logic [7:0] SCOPE_WIFI = 8'd1;
  localparam logic [7:0] SCOPE_BLE  = 8'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LIST  = 2'd1,
    CMD_SSID  = 2'd2,
    CMD_MATCH = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [4:0]  byte_index;
    logic [47:0] mac_address;
    logic        is_ble;
    logic [5:0]  ssid_len;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [4:0]  entry_count;
    logic [31:0] list_version;
    logic        list_changed;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic k_inc;
    logic j_clr;
    logic j_inc;
    logic sl_load;
    logic commit;
    logic set_hit;
    logic res_load;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic count_ne;
    logic k_end;
    logic hdr_ne;
    logic j_last;
    logic byte_ne;
    logic rule_ok;
    logic scan_go;
    logic bank;
  } dp_sts_t;

endpackage

@@ rtl/core/mosif_if.sv @@
// Valid/ready channel interfaces for input items and results
interface mosif_in_if;
  import mosif_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mosif_out_if;
  import mosif_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/mac_oui_ssid_ignore_filter.sv @@
// Top level of the MAC / OUI / SSID ignore filter
//
// Usage: items arrive on in_i (valid/ready), one result per item leaves on
// out_o (valid/ready). A transfer happens when valid and ready are both high.
// Items are: clear the live list, one byte of a list stream, one byte of the
// query SSID, or a match query. The block works on one item at a time.
// Path from input transfer to result, by item:
//   clear, SSID byte, list byte that is not the last: the item is taken in
//     idle and the result is loaded from the done state.
//   last list byte: a header step per rule, then a read and a check per value
//     byte, in a byte-serial compare of the two rule banks through one RAM
//     read port each; a count, header or byte difference ends it early.
//   match query: a scan of up to 32 query SSID bytes, then a header step per
//     rule and a read and a check per compared byte, to a hit or list end.
// Commit of a new list flips the live/shadow bank pointer: no copy pass.
// A finished result sits in an output register; a new item is taken while it
// waits, but the next result holds until the receiver takes the old one.
// Reset empties the live list, zeroes the version and restarts the parser;
// rule and SSID storage are undefined until written, with no clearing pass.
`include "mac_oui_ssid_ignore_filter_assert.svh"
module mac_oui_ssid_ignore_filter (
  input logic        clk_i,
  input logic        rst_ni,
  mosif_in_if.sink   in_i,
  mosif_out_if.source out_o
);
  import mosif_pkg::*;

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  out_item_t res;
  logic      in_ready;
  logic      out_valid;

  // Sequencing
  mosif_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_ready),
    .in_cmd_i    (in_i.data.command),
    .in_last_i   (in_i.data.last_byte),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Storage and compare
  mosif_datapath u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_i.data),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res)
  );

  assign in_i.ready = in_ready;
  assign out_o.valid = out_valid;
  assign out_o.data  = res;

  // Checks
  `MOSIF_ASSERT_NXT(a_busy_after_transfer, clk_i, rst_ni, in_i.valid && in_ready, !in_ready)
  `MOSIF_ASSERT_NXT(a_commit_flips_bank, clk_i, rst_ni, cmd.commit, sts.bank != $past(sts.bank))
  `MOSIF_ASSERT_IMP(a_hit_only_on_match, clk_i, rst_ni, cmd.set_hit, sts.cmd == CMD_MATCH)
endmodule

@@ rtl/core/mosif_ram.sv @@
// Generic single-write, single-read RAM with registered read data
module mosif_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

@@ rtl/core/mosif_datapath.sv @@
// Datapath: list parser, double-banked rule store, query buffer, compare logic
module mosif_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mosif_pkg::in_item_t  item_i,
  input  mosif_pkg::dp_cmd_t   cmd_i,
  output mosif_pkg::dp_sts_t   sts_o,
  output mosif_pkg::out_item_t res_o
);
  import mosif_pkg::*;

  typedef enum logic [5:0] {
    PH_COUNT = 6'b000001,
    PH_TYPE  = 6'b000010,
    PH_SCOPE = 6'b000100,
    PH_LEN   = 6'b001000,
    PH_VALUE = 6'b010000,
    PH_HALT  = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0]    rtype;
    logic [7:0]    scope;
    logic [LW-1:0] len;
  } hdr_t;

  // Control state
  phase_e        phase_q, phase_d;
  logic [LW-1:0] off_q, off_d;
  logic [LW-1:0] cur_len_q, cur_len_d;
  logic [CW-1:0] shd_cnt_q, shd_cnt_d;
  logic [CW-1:0] live_cnt_q, live_cnt_d;
  logic [31:0]   ver_q, ver_d;
  logic          bank_q, bank_d;
  logic [CW-1:0] k_q, k_d;
  logic [JW-1:0] j_q, j_d;
  logic          hit_q, hit_d;
  logic          chg_q, chg_d;

  // Payload state
  hdr_t        hdr_q [2][ENTRIES];
  logic [7:0]  qs_q [SSID_CAP];
  logic [47:0] mac_q;
  logic        ble_q;
  logic [5:0]  slen_q;
  logic [5:0]  sl_q;
  cmd_e        cmd_q;
  out_item_t   res_q;

  logic          is_list;
  logic          full;
  logic          we_type, we_scope, we_len, ram_we;
  logic [EW-1:0] nidx, kidx;
  logic [LW-1:0] off_inc;
  logic          shd_bank;
  hdr_t          lhdr, shdr;
  logic [7:0]    rd0, rd1, live_byte, shd_byte, mac_byte, ref_byte;
  logic          scope_ok;
  logic [JW-1:0] need, len_ext;

  assign is_list  = cmd_i.accept && (item_i.command == CMD_LIST);
  assign full     = (shd_cnt_q >= CW'(ENTRIES));
  assign nidx     = shd_cnt_q[EW-1:0];
  assign kidx     = k_q[EW-1:0];
  assign off_inc  = off_q + LW'(1);
  assign shd_bank = ~bank_q;

  // List stream parser
  always_comb begin
    phase_d   = phase_q;
    off_d     = off_q;
    cur_len_d = cur_len_q;
    shd_cnt_d = shd_cnt_q;
    we_type   = 1'b0;
    we_scope  = 1'b0;
    we_len    = 1'b0;
    ram_we    = 1'b0;
    if (is_list) begin
      case (phase_q)
        PH_COUNT: begin
          shd_cnt_d = '0;
          phase_d   = PH_TYPE;
        end
        PH_TYPE: begin
          if (full) phase_d = PH_HALT;
          else begin
            we_type = 1'b1;
            phase_d = PH_SCOPE;
          end
        end
        PH_SCOPE: begin
          if (full) phase_d = PH_HALT;
          else begin
            we_scope = 1'b1;
            phase_d  = PH_LEN;
          end
        end
        PH_LEN: begin
          if (full || item_i.data_byte == 8'd0 ||
              item_i.data_byte > 8'(VALUE_MAX)) begin
            phase_d = PH_HALT;
          end else begin
            we_len    = 1'b1;
            cur_len_d = item_i.data_byte[LW-1:0];
            off_d     = '0;
            phase_d   = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (full || off_q >= LW'(VALUE_MAX)) phase_d = PH_HALT;
          else begin
            ram_we = 1'b1;
            off_d  = off_inc;
            if (off_inc >= cur_len_q) begin
              shd_cnt_d = shd_cnt_q + CW'(1);
              phase_d   = (shd_cnt_d >= CW'(ENTRIES)) ? PH_HALT : PH_TYPE;
            end
          end
        end
        PH_HALT: ;
        default: phase_d = PH_COUNT;
      endcase
      if (item_i.last_byte) begin
        phase_d = PH_COUNT;
        off_d   = '0;
      end
    end
  end

  // Live list, version, scan counters and flags
  always_comb begin
    live_cnt_d = live_cnt_q;
    ver_d      = ver_q;
    bank_d     = bank_q;
    k_d        = k_q;
    j_d        = j_q;
    hit_d      = hit_q;
    chg_d      = chg_q;
    if (cmd_i.accept) begin
      k_d   = '0;
      j_d   = '0;
      hit_d = 1'b0;
      chg_d = 1'b0;
      if (item_i.command == CMD_CLEAR) begin
        live_cnt_d = '0;
        ver_d      = ver_q + 32'd1;
        chg_d      = 1'b1;
      end
    end
    if (cmd_i.commit) begin
      bank_d     = ~bank_q;
      live_cnt_d = shd_cnt_q;
      ver_d      = ver_q + 32'd1;
      chg_d      = 1'b1;
    end
    if (cmd_i.k_inc) k_d = k_q + CW'(1);
    if (cmd_i.j_clr) j_d = '0;
    if (cmd_i.j_inc) j_d = j_q + JW'(1);
    if (cmd_i.set_hit) hit_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_COUNT;
      off_q      <= '0;
      cur_len_q  <= '0;
      shd_cnt_q  <= '0;
      live_cnt_q <= '0;
      ver_q      <= '0;
      bank_q     <= 1'b0;
      k_q        <= '0;
      j_q        <= '0;
      hit_q      <= 1'b0;
      chg_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      off_q      <= off_d;
      cur_len_q  <= cur_len_d;
      shd_cnt_q  <= shd_cnt_d;
      live_cnt_q <= live_cnt_d;
      ver_q      <= ver_d;
      bank_q     <= bank_d;
      k_q        <= k_d;
      j_q        <= j_d;
      hit_q      <= hit_d;
      chg_q      <= chg_d;
    end
  end

  // Shadow headers, query buffer, latched query and result
  always_ff @(posedge clk_i) begin
    if (we_type)  hdr_q[shd_bank][nidx].rtype <= item_i.data_byte;
    if (we_scope) hdr_q[shd_bank][nidx].scope <= item_i.data_byte;
    if (we_len)   hdr_q[shd_bank][nidx].len   <= item_i.data_byte[LW-1:0];
    if (cmd_i.accept && item_i.command == CMD_SSID) begin
      qs_q[item_i.byte_index] <= item_i.data_byte;
    end
    if (cmd_i.accept) begin
      cmd_q  <= item_i.command;
      mac_q  <= item_i.mac_address;
      ble_q  <= item_i.is_ble;
      slen_q <= (item_i.ssid_len > 6'(SSID_CAP)) ? 6'(SSID_CAP) : item_i.ssid_len;
    end
    if (cmd_i.sl_load) sl_q <= j_q[5:0];
    if (cmd_i.res_load) begin
      res_q.hit          <= hit_q;
      res_q.entry_count  <= 5'(live_cnt_q);
      res_q.list_version <= ver_q;
      res_q.list_changed <= chg_q;
    end
  end

  // Value banks: the one not live takes the stream
  mosif_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_bank0 (
    .clk_i   (clk_i),
    .we_i    (ram_we & bank_q),
    .waddr_i ({nidx, off_q[VW-1:0]}),
    .wdata_i (item_i.data_byte),
    .raddr_i ({kidx, j_q[VW-1:0]}),
    .rdata_o (rd0)
  );

  mosif_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_bank1 (
    .clk_i   (clk_i),
    .we_i    (ram_we & ~bank_q),
    .waddr_i ({nidx, off_q[VW-1:0]}),
    .wdata_i (item_i.data_byte),
    .raddr_i ({kidx, j_q[VW-1:0]}),
    .rdata_o (rd1)
  );

  assign live_byte = bank_q ? rd1 : rd0;
  assign shd_byte  = bank_q ? rd0 : rd1;
  assign lhdr      = hdr_q[bank_q][kidx];
  assign shdr      = hdr_q[shd_bank][kidx];
  assign len_ext   = JW'(lhdr.len);

  // MAC byte in transmit order
  always_comb begin
    case (j_q[2:0])
      3'd0:    mac_byte = mac_q[47:40];
      3'd1:    mac_byte = mac_q[39:32];
      3'd2:    mac_byte = mac_q[31:24];
      3'd3:    mac_byte = mac_q[23:16];
      3'd4:    mac_byte = mac_q[15:8];
      3'd5:    mac_byte = mac_q[7:0];
      default: mac_byte = 8'h00;
    endcase
  end

  assign ref_byte = (lhdr.rtype == TYPE_SSID) ? qs_q[j_q[4:0]] : mac_byte;

  // Rule applicability and required length
  assign scope_ok = !((lhdr.scope == SCOPE_WIFI && ble_q) ||
                      (lhdr.scope == SCOPE_BLE && !ble_q));
  always_comb begin
    case (lhdr.rtype)
      TYPE_MAC:  need = JW'(6);
      TYPE_OUI:  need = JW'(3);
      TYPE_SSID: need = JW'(sl_q);
      default:   need = '0;
    endcase
  end

  assign sts_o.cmd      = cmd_q;
  assign sts_o.count_ne = (shd_cnt_q != live_cnt_q);
  assign sts_o.k_end    = (k_q == live_cnt_q);
  assign sts_o.hdr_ne   = (lhdr != shdr);
  assign sts_o.j_last   = ((j_q + JW'(1)) == len_ext);
  assign sts_o.byte_ne  = (cmd_q == CMD_MATCH) ? (live_byte != ref_byte)
                                               : (live_byte != shd_byte);
  assign sts_o.rule_ok  = scope_ok && (need != '0) && (len_ext == need);
  assign sts_o.scan_go  = (j_q < JW'(slen_q)) && (qs_q[j_q[4:0]] != 8'd0);
  assign sts_o.bank     = bank_q;
  assign res_o          = res_q;
endmodule

@@ rtl/core/mosif_ctrl.sv @@
// Controller: sequences parse commit, list compare, SSID scan and rule match
module mosif_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mosif_pkg::cmd_e    in_cmd_i,
  input  logic               in_last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  mosif_pkg::dp_sts_t sts_i,
  output mosif_pkg::dp_cmd_t cmd_o
);
  import mosif_pkg::*;

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b0000000001,
    ST_CMP_HDR = 10'b0000000010,
    ST_CMP_RD  = 10'b0000000100,
    ST_CMP_CHK = 10'b0000001000,
    ST_COMMIT  = 10'b0000010000,
    ST_SCAN    = 10'b0000100000,
    ST_MT_HDR  = 10'b0001000000,
    ST_MT_RD   = 10'b0010000000,
    ST_MT_CHK  = 10'b0100000000,
    ST_DONE    = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (in_cmd_i == CMD_LIST && in_last_i) state_d = ST_CMP_HDR;
          else if (in_cmd_i == CMD_MATCH)        state_d = ST_SCAN;
          else                                   state_d = ST_DONE;
        end
      end
      ST_CMP_HDR: begin
        if (sts_i.count_ne)    state_d = ST_COMMIT;
        else if (sts_i.k_end)  state_d = ST_DONE;
        else if (sts_i.hdr_ne) state_d = ST_COMMIT;
        else begin
          cmd_o.j_clr = 1'b1;
          state_d     = ST_CMP_RD;
        end
      end
      ST_CMP_RD: state_d = ST_CMP_CHK;
      ST_CMP_CHK: begin
        if (sts_i.byte_ne) state_d = ST_COMMIT;
        else if (sts_i.j_last) begin
          cmd_o.k_inc = 1'b1;
          state_d     = ST_CMP_HDR;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = ST_CMP_RD;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_DONE;
      end
      ST_SCAN: begin
        if (sts_i.scan_go) cmd_o.j_inc = 1'b1;
        else begin
          cmd_o.sl_load = 1'b1;
          state_d       = ST_MT_HDR;
        end
      end
      ST_MT_HDR: begin
        if (sts_i.k_end) state_d = ST_DONE;
        else if (sts_i.rule_ok) begin
          cmd_o.j_clr = 1'b1;
          state_d     = ST_MT_RD;
        end else begin
          cmd_o.k_inc = 1'b1;
        end
      end
      ST_MT_RD: state_d = ST_MT_CHK;
      ST_MT_CHK: begin
        if (sts_i.byte_ne) begin
          cmd_o.k_inc = 1'b1;
          state_d     = ST_MT_HDR;
        end else if (sts_i.j_last) begin
          cmd_o.set_hit = 1'b1;
          state_d       = ST_DONE;
        end else begin
          cmd_o.j_inc = 1'b1;
          state_d     = ST_MT_RD;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd_o.res_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.res_load)             out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

@@ tb/mac_oui_ssid_ignore_filter_tb.sv @@
// Testbench for the ignore filter: scored random and directed traffic against a local predictor
`timescale 1ns / 1ps
module mac_oui_ssid_ignore_filter_tb;
  import mosif_pkg::*;

  localparam int PH_COUNT = 0;
  localparam int PH_TYPE  = 1;
  localparam int PH_SCOPE = 2;
  localparam int PH_LEN   = 3;
  localparam int PH_VALUE = 4;
  localparam int PH_HALT  = 5;
  localparam logic [7:0] SCOPE_ANY = 8'd0;

  logic clk_i;
  logic rst_ni;

  mosif_in_if  in_if ();
  mosif_out_if out_if ();

  mac_oui_ssid_ignore_filter u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Filter state as predicted
  logic [7:0]  live_type [ENTRIES];
  logic [7:0]  live_scope[ENTRIES];
  logic [7:0]  live_len  [ENTRIES];
  logic [7:0]  live_val  [ENTRIES][VALUE_MAX];
  logic [7:0]  shd_type  [ENTRIES];
  logic [7:0]  shd_scope [ENTRIES];
  logic [7:0]  shd_len   [ENTRIES];
  logic [7:0]  shd_val   [ENTRIES][VALUE_MAX];
  logic [7:0]  ssid_buf  [SSID_CAP];
  int          live_cnt;
  int          shd_cnt;
  int          phase;
  int          offset;
  logic [31:0] version;

  out_item_t result_q[$];
  int        mismatches;
  int        hold_cycles;

  // Stimulus pools so that matches can hit
  logic [47:0] mac_pool[4];
  logic [7:0]  name_pool[3][8];
  int          name_len[3];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Parser of one list stream byte
  function automatic void parse_byte(logic [7:0] b);
    case (phase)
      PH_COUNT: begin
        shd_cnt = 0;
        phase = PH_TYPE;
      end
      PH_TYPE: begin
        if (shd_cnt >= ENTRIES) phase = PH_HALT;
        else begin
          shd_type[shd_cnt] = b;
          phase = PH_SCOPE;
        end
      end
      PH_SCOPE: begin
        if (shd_cnt >= ENTRIES) phase = PH_HALT;
        else begin
          shd_scope[shd_cnt] = b;
          phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (shd_cnt >= ENTRIES || b == 8'd0 || b > VALUE_MAX) phase = PH_HALT;
        else begin
          shd_len[shd_cnt] = b;
          offset = 0;
          phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (shd_cnt >= ENTRIES || offset >= VALUE_MAX) phase = PH_HALT;
        else begin
          shd_val[shd_cnt][offset] = b;
          offset++;
          if (offset >= shd_len[shd_cnt]) begin
            shd_cnt++;
            phase = (shd_cnt >= ENTRIES) ? PH_HALT : PH_TYPE;
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Commit the parsed list when it differs in anything meaningful
  function automatic bit commit_list();
    bit same;
    same = (shd_cnt == live_cnt);
    for (int k = 0; k < shd_cnt && same; k++) begin
      if (shd_type[k] != live_type[k] || shd_scope[k] != live_scope[k] ||
          shd_len[k] != live_len[k]) same = 0;
      else
        for (int i = 0; i < shd_len[k]; i++)
          if (shd_val[k][i] != live_val[k][i]) same = 0;
    end
    if (same) return 0;
    live_type  = shd_type;
    live_scope = shd_scope;
    live_len   = shd_len;
    live_val   = shd_val;
    live_cnt   = shd_cnt;
    version++;
    return 1;
  endfunction

  function automatic bit match_rules(logic [47:0] mac, logic ble, logic [5:0] slen);
    logic [7:0] m[6];
    int sl;
    int lim;
    bit eq;
    for (int i = 0; i < 6; i++) m[i] = mac[47 - 8*i -: 8];
    lim = (int'(slen) > SSID_CAP) ? SSID_CAP : int'(slen);
    sl = 0;
    while (sl < lim && ssid_buf[sl] != 8'd0) sl++;
    for (int k = 0; k < live_cnt; k++) begin
      if (live_scope[k] == SCOPE_WIFI && ble) continue;
      if (live_scope[k] == SCOPE_BLE && !ble) continue;
      eq = 1;
      if (live_type[k] == TYPE_MAC) begin
        if (live_len[k] != 6) continue;
        for (int i = 0; i < 6; i++) if (live_val[k][i] != m[i]) eq = 0;
        if (eq) return 1;
      end else if (live_type[k] == TYPE_OUI) begin
        if (live_len[k] != 3) continue;
        for (int i = 0; i < 3; i++) if (live_val[k][i] != m[i]) eq = 0;
        if (eq) return 1;
      end else if (live_type[k] == TYPE_SSID) begin
        if (sl == 0 || live_len[k] != sl) continue;
        for (int i = 0; i < sl; i++) if (live_val[k][i] != ssid_buf[i]) eq = 0;
        if (eq) return 1;
      end
    end
    return 0;
  endfunction

  function automatic out_item_t filter_step(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.command)
      CMD_CLEAR: begin
        live_cnt = 0;
        version++;
        r.list_changed = 1'b1;
      end
      CMD_LIST: begin
        parse_byte(it.data_byte);
        if (it.last_byte) begin
          r.list_changed = commit_list();
          phase = PH_COUNT;
          offset = 0;
        end
      end
      CMD_SSID: ssid_buf[it.byte_index] = it.data_byte;
      default: r.hit = match_rules(it.mac_address, it.is_ble, it.ssid_len);
    endcase
    r.entry_count  = live_cnt[4:0];
    r.list_version = version;
    return r;
  endfunction

  // Sends one item, predicts it at the transfer, then at random idles for a while
  task automatic send_item(cmd_e cmd, logic [7:0] data = 8'd0, logic last = 1'b0,
                           logic [4:0] idx = 5'd0, logic [47:0] mac = 48'd0,
                           logic ble = 1'b0, logic [5:0] slen = 6'd0);
    in_item_t it;
    int sel;
    it.command     = cmd;
    it.data_byte   = data;
    it.last_byte   = last;
    it.byte_index  = idx;
    it.mac_address = mac;
    it.is_ble      = ble;
    it.ssid_len    = slen;
    in_if.data  = it;
    in_if.valid = 1'b1;
    // Ready only moves at the rising edge, so it is read while the clock is low
    while (!in_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    result_q.push_back(filter_step(it));
    @(negedge clk_i);
    sel = $urandom_range(0, 99);
    if (sel >= 70) begin
      in_if.valid = 1'b0;
      in_if.data  = in_item_t'({$urandom, $urandom, 7'($urandom)});
      repeat ((sel >= 96) ? $urandom_range(10, 40) : $urandom_range(1, 3))
        @(negedge clk_i);
    end
  endtask

  // Result checker and receiver stalls
  initial begin
    out_item_t exp_r;
    out_item_t got;
    bit        take;
    int sel;
    out_if.ready = 1'b0;
    mismatches = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_if.ready = 1'b0;
        hold_cycles--;
      end else begin
        sel = $urandom_range(0, 99);
        out_if.ready = (sel < 75);
      end
      // Valid and data are registered: these are the values at the rising edge
      take = rst_ni && out_if.valid && out_if.ready;
      got  = out_if.data;
      @(posedge clk_i);
      if (take) begin
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          exp_r = result_q.pop_front();
          if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected %p, got %p", exp_r, got);
          end
        end
      end
    end
  end

  task automatic send_stream(logic [7:0] bytes[$]);
    foreach (bytes[i]) send_item(CMD_LIST, bytes[i], i == bytes.size() - 1);
  endtask

  // Query SSID into the buffer, zero terminated where room allows
  task automatic load_name(int n);
    for (int i = 0; i < name_len[n]; i++) send_item(CMD_SSID, name_pool[n][i], 0, 5'(i));
    send_item(CMD_SSID, 8'd0, 0, 5'(name_len[n]));
  endtask

  // Whole query buffer written first so no match reads an unset byte
  task automatic test_ssid_buffer();
    for (int i = 0; i < SSID_CAP; i++)
      send_item(CMD_SSID, 8'($urandom_range(1, 255)), 0, 5'(i));
  endtask

  task automatic test_directed();
    logic [7:0] s[$];
    send_item(CMD_CLEAR);
    // MAC wifi, OUI ble, SSID of any scope (scope code 7)
    s = {8'd4, TYPE_MAC, SCOPE_WIFI, 8'd6, mac_pool[0][47:40], mac_pool[0][39:32],
         mac_pool[0][31:24], mac_pool[0][23:16], mac_pool[0][15:8], mac_pool[0][7:0],
         TYPE_OUI, SCOPE_BLE, 8'd3, mac_pool[1][47:40], mac_pool[1][39:32],
         mac_pool[1][31:24], TYPE_SSID, 8'd7, 8'd4, name_pool[0][0], name_pool[0][1],
         name_pool[0][2], name_pool[0][3]};
    send_stream(s);
    send_stream(s);
    send_item(CMD_MATCH, 0, 0, 0, mac_pool[0], 1'b0, 6'd0);
    send_item(CMD_MATCH, 0, 0, 0, mac_pool[0], 1'b1, 6'd0);
    send_item(CMD_MATCH, 0, 0, 0, {mac_pool[1][47:24], 24'hFFFFFF}, 1'b1, 6'd0);
    load_name(0);
    send_item(CMD_MATCH, 0, 0, 0, 48'hFFFF_FFFF_FFFF, 1'b1, 6'd63);
    // Bad length halts; last byte still commits the first record
    s = {8'd0, TYPE_OUI, SCOPE_ANY, 8'd3, 8'hAA, 8'hBB, 8'hCC, TYPE_MAC, 8'd0, 8'd33,
         8'd1, 8'd2};
    send_stream(s);
    send_item(CMD_MATCH, 0, 0, 0, 48'hAABBCC_000000, 1'b0, 6'd0);
  endtask

  function automatic void add_rule(ref logic [7:0] s[$]);
    int t;
    int len;
    int p;
    t = $urandom_range(0, 9);
    p = $urandom_range(0, 3);
    s.push_back(t < 3 ? TYPE_MAC : t < 6 ? TYPE_OUI : t < 9 ? TYPE_SSID :
                8'($urandom_range(3, 255)));
    s.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
    if (t < 6) begin
      len = (t < 3) ? 6 : 3;
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 8);
      s.push_back(8'(len));
      for (int i = 0; i < len; i++)
        s.push_back(i < 6 ? mac_pool[p][47 - 8*i -: 8] : 8'($urandom));
    end else begin
      p = p % 3;
      len = name_len[p];
      if ($urandom_range(0, 9) == 0) len = $urandom_range(1, VALUE_MAX);
      s.push_back(8'(len));
      for (int i = 0; i < len; i++) s.push_back(i < 8 ? name_pool[p][i] : 8'($urandom));
    end
  endfunction

  task automatic test_random(int items);
    logic [7:0] s[$];
    logic [7:0] prev[$];
    int sent;
    int kind;
    int n;
    int q;
    sent = 0;
    while (sent < items) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        // A list stream, mostly well formed
        s = {8'($urandom)};
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 5);
        for (int r = 0; r < n; r++) add_rule(s);
        q = $urandom_range(0, 9);
        if (q == 0 && s.size() > 2) s = s[0:s.size() - 2];
        else if (q == 1) repeat ($urandom_range(1, 5)) s.push_back(8'($urandom));
        else if (q == 2 && prev.size() > 0) s = prev;
        prev = s;
        foreach (s[i]) begin
          if ($urandom_range(0, 49) == 0) send_item(CMD_CLEAR);
          send_item(CMD_LIST, s[i], i == s.size() - 1);
        end
        sent += s.size();
      end else if (kind < 40) begin
        n = $urandom_range(0, 2);
        load_name(n);
        sent += name_len[n] + 1;
      end else if (kind < 80) begin
        q = $urandom_range(0, 9);
        send_item(CMD_MATCH, 8'($urandom), 1'($urandom), 5'($urandom),
                  q < 7 ? {mac_pool[$urandom_range(0, 3)][47:24],
                           (q < 4 ? mac_pool[$urandom_range(0, 3)][23:0] : 24'($urandom))}
                        : {16'($urandom), 32'($urandom)},
                  1'($urandom), 6'($urandom_range(0, 63)));
        sent++;
      end else if (kind < 85) begin
        send_item(CMD_CLEAR, 8'($urandom), 1'($urandom), 5'($urandom));
        sent++;
      end else begin
        send_item(CMD_SSID, 8'($urandom), 1'($urandom), 5'($urandom),
                  {16'($urandom), 32'($urandom)}, 1'($urandom), 6'($urandom));
        sent++;
      end
    end
  endtask

  // Receiver stalls long while items keep coming
  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 12; i++) send_item(CMD_SSID, 8'($urandom_range(1, 255)), 0, 5'(i));
    repeat (8)
      send_item(CMD_MATCH, 0, 0, 0, mac_pool[$urandom_range(0, 3)], 1'($urandom), 6'd32);
  endtask

  initial begin
    int guard;
    hold_cycles = 0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    rst_ni = 1'b0;
    live_cnt = 0;
    shd_cnt = 0;
    phase = PH_COUNT;
    offset = 0;
    version = '0;
    foreach (mac_pool[i]) mac_pool[i] = {16'($urandom), 32'($urandom)};
    foreach (name_len[i]) begin
      name_len[i] = $urandom_range(1, 8);
      for (int j = 0; j < 8; j++) name_pool[i][j] = 8'($urandom_range(1, 255));
    end
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_ssid_buffer();
    test_directed();
    test_random(600);
    test_backpressure();

    in_if.valid = 1'b0;
    guard = 0;
    while (result_q.size() > 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
